// ===== hdl/cth_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cth_pkg
// Shared sizes, register indexes and controller types for the cache tag
// hit tracker.
// ============================================================================
package cth_pkg;

    // Cache geometry
    localparam int LINES     = 64;
    localparam int ADDR_BITS = 20;
    localparam int SETS      = LINES / 2;
    localparam int IDX_W     = $clog2(LINES);
    localparam int SET_W     = $clog2(SETS);
    localparam int TAG_W     = ADDR_BITS;
    localparam int SHIFT_W   = 5;
    localparam int CNT_W     = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CACHE_MODE     = 3'd0,
        CFG_DM_OFFSET_BITS = 3'd1,
        CFG_DM_INDEX_BITS  = 3'd2,
        CFG_SA_OFFSET_BITS = 3'd3,
        CFG_SA_INDEX_BITS  = 3'd4
    } cfg_reg_t;

    // Access kinds and modes
    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_STORE      = 1'b1;
    localparam logic MODE_DIRECT   = 1'b0;
    localparam logic MODE_TWO_WAY  = 1'b1;

    // Controller states
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } ctl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the input transaction and start the tag read
        logic commit;  // resolve hit/miss, update state and load the result
    } ctl_cmd_t;

endpackage

// ===== hdl/cache_tag_hit_tracker_core.sv =====
`timescale 1ns / 1ps
// An accepted transaction is captured and starts a registered tag RAM read; the
// compare-and-update step then puts its result in the output register when free.
// No new transaction is taken until the previous one has been committed.
// A new transaction is taken while a finished result waits in the output register.
// Reset clears valid bits, LRU bits, counters and restores configuration defaults;
// tag RAM contents are left as they are, with no clearing pass.
// ============================================================================
// cache_tag_hit_tracker_core
// Tag store of a small write-through data cache, direct mapped or two-way LRU,
// reporting hit, way and running hit/access totals per load or store.
// ============================================================================
module cache_tag_hit_tracker_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cth_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cth_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [cth_pkg::ADDR_BITS-1:0]  address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic                           way_used,
    output logic [cth_pkg::CNT_W-1:0]      hit_total,
    output logic [cth_pkg::CNT_W-1:0]      access_total
);

    cth_pkg::ctl_cmd_t cmd;

    // Sequencing
    cth_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Tag lookup and state
    cth_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .address      (address),
        .hit          (hit),
        .way_used     (way_used),
        .hit_total    (hit_total),
        .access_total (access_total)
    );

endmodule

// ===== hdl/cth_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cth_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cth_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cth_ctrl
// Controller: accepts one transaction, waits for the tag read, then commits
// the result into the output register when it is free.
// ============================================================================
module cth_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output cth_pkg::ctl_cmd_t cmd
);

    cth_pkg::ctl_state_t state_reg;
    cth_pkg::ctl_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    // Output register can take a result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cth_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cth_pkg::ST_LOOKUP;
                end
            end
            cth_pkg::ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = cth_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cth_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_stall   = 1'b1;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            cth_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            cth_pkg::ST_LOOKUP:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Output valid: set on commit, drop when taken
    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cth_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result committed over a stalled result");

    // A captured transaction goes to lookup
    a_load_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == cth_pkg::ST_LOOKUP))
        else $error("load did not enter lookup");

    // A commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise out_valid");

    // Load and commit never coincide
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.commit))
        else $error("load and commit in the same cycle");

endmodule

// ===== hdl/cth_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cth_datapath
// Configuration registers, address split, tag RAMs (one per way), valid and
// LRU bits, hit/miss resolution and running counters.
// ============================================================================
module cth_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cth_pkg::ctl_cmd_t                cmd,
    input  logic                             cfg_we,
    input  logic [cth_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cth_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             operation,
    input  logic [cth_pkg::ADDR_BITS-1:0]    address,
    output logic                             hit,
    output logic                             way_used,
    output logic [cth_pkg::CNT_W-1:0]        hit_total,
    output logic [cth_pkg::CNT_W-1:0]        access_total
);

    localparam logic [2:0] DM_IB_MAX = 3'(cth_pkg::IDX_W);
    localparam logic [2:0] SA_IB_MAX = 3'(cth_pkg::SET_W);

    // Configuration registers
    logic       cache_mode_reg;
    logic [3:0] dm_offset_bits_reg;
    logic [2:0] dm_index_bits_reg;
    logic [3:0] sa_offset_bits_reg;
    logic [2:0] sa_index_bits_reg;

    // Captured transaction
    logic                        op_reg;
    logic [cth_pkg::IDX_W-1:0]   ent_reg;
    logic [cth_pkg::TAG_W-1:0]   tag_reg;

    // Cache state
    logic [cth_pkg::LINES-1:0]   valid_reg;
    logic [cth_pkg::SETS-1:0]    lru_reg;
    logic [cth_pkg::CNT_W-1:0]   hit_cnt_reg;
    logic [cth_pkg::CNT_W-1:0]   acc_cnt_reg;
    logic                        hit_out_reg;
    logic                        way_out_reg;

    // Address split
    logic [2:0]                  dm_ib;
    logic [2:0]                  sa_ib;
    logic [3:0]                  off_bits;
    logic [2:0]                  idx_bits;
    logic [cth_pkg::SHIFT_W-1:0] tag_shift;
    logic [cth_pkg::ADDR_BITS-1:0] addr_shifted;
    logic [cth_pkg::IDX_W-1:0]   idx_mask;
    logic [cth_pkg::IDX_W-1:0]   idx_raw;
    logic [cth_pkg::IDX_W-1:0]   ent_next;
    logic [cth_pkg::TAG_W-1:0]   tag_next;
    logic [cth_pkg::SET_W-1:0]   rd_row;
    logic [cth_pkg::SET_W-1:0]   row;

    // Lookup
    logic [cth_pkg::TAG_W-1:0]   rd_tag0;
    logic [cth_pkg::TAG_W-1:0]   rd_tag1;
    logic                        match0;
    logic                        match1;
    logic                        hit_now;
    logic                        way_now;
    logic                        alloc;
    logic                        wr_way;
    logic                        we0;
    logic                        we1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_mode_reg     <= cth_pkg::MODE_DIRECT;
            dm_offset_bits_reg <= 4'd5;
            dm_index_bits_reg  <= 3'd5;
            sa_offset_bits_reg <= 4'd6;
            sa_index_bits_reg  <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cth_pkg::CFG_CACHE_MODE:     cache_mode_reg     <= cfg_data[0];
                cth_pkg::CFG_DM_OFFSET_BITS: dm_offset_bits_reg <= cfg_data;
                cth_pkg::CFG_DM_INDEX_BITS:  dm_index_bits_reg  <= cfg_data[2:0];
                cth_pkg::CFG_SA_OFFSET_BITS: sa_offset_bits_reg <= cfg_data;
                cth_pkg::CFG_SA_INDEX_BITS:  sa_index_bits_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Clamp index bits to the geometry and split the address
    always_comb
    begin
        dm_ib = (dm_index_bits_reg > DM_IB_MAX) ? DM_IB_MAX : dm_index_bits_reg;
        sa_ib = (sa_index_bits_reg > SA_IB_MAX) ? SA_IB_MAX : sa_index_bits_reg;
        if (cache_mode_reg == cth_pkg::MODE_TWO_WAY)
        begin
            off_bits = sa_offset_bits_reg;
            idx_bits = sa_ib;
        end
        else
        begin
            off_bits = dm_offset_bits_reg;
            idx_bits = dm_ib;
        end
        tag_shift    = cth_pkg::SHIFT_W'(off_bits) + cth_pkg::SHIFT_W'(idx_bits);
        addr_shifted = address >> off_bits;
        idx_mask     = cth_pkg::IDX_W'((1 << idx_bits) - 1);
        idx_raw      = addr_shifted[cth_pkg::IDX_W-1:0] & idx_mask;
        tag_next     = cth_pkg::TAG_W'(address >> tag_shift);
        // Two-way: entry of way 0 of the set; direct mapped: the line itself
        if (cache_mode_reg == cth_pkg::MODE_TWO_WAY)
        begin
            ent_next = {idx_raw[cth_pkg::SET_W-1:0], 1'b0};
        end
        else
        begin
            ent_next = idx_raw;
        end
        rd_row = ent_next[cth_pkg::IDX_W-1:1];
    end

    // Capture the transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            ent_reg <= ent_next;
            tag_reg <= tag_next;
        end
    end

    assign row = ent_reg[cth_pkg::IDX_W-1:1];

    // Tag RAMs: way 0 holds even entries, way 1 odd entries
    cth_ram #(
        .WIDTH (cth_pkg::TAG_W),
        .DEPTH (cth_pkg::SETS)
    ) u_tag_way0 (
        .clk   (clk),
        .we    (we0),
        .waddr (row),
        .wdata (tag_reg),
        .re    (cmd.load),
        .raddr (rd_row),
        .rdata (rd_tag0)
    );

    cth_ram #(
        .WIDTH (cth_pkg::TAG_W),
        .DEPTH (cth_pkg::SETS)
    ) u_tag_way1 (
        .clk   (clk),
        .we    (we1),
        .waddr (row),
        .wdata (tag_reg),
        .re    (cmd.load),
        .raddr (rd_row),
        .rdata (rd_tag1)
    );

    // Resolve hit, way and allocation
    always_comb
    begin
        match0 = valid_reg[{row, 1'b0}] && (rd_tag0 == tag_reg);
        match1 = valid_reg[{row, 1'b1}] && (rd_tag1 == tag_reg);
        if (cache_mode_reg == cth_pkg::MODE_TWO_WAY)
        begin
            hit_now = match0 || match1;
            priority if (match0)
            begin
                way_now = 1'b0;
            end
            else if (match1)
            begin
                way_now = 1'b1;
            end
            else
            begin
                way_now = lru_reg[row];
            end
            alloc  = !hit_now;
            wr_way = way_now;
        end
        else
        begin
            hit_now = ent_reg[0] ? match1 : match0;
            way_now = 1'b0;
            alloc   = !hit_now && (op_reg == cth_pkg::OP_LOAD);
            wr_way  = ent_reg[0];
        end
        we0 = cmd.commit && alloc && !wr_way;
        we1 = cmd.commit && alloc && wr_way;
    end

    // Update valid, LRU and counters on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            lru_reg     <= '0;
            hit_cnt_reg <= '0;
            acc_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (alloc)
            begin
                valid_reg[{row, wr_way}] <= 1'b1;
            end
            if (cache_mode_reg == cth_pkg::MODE_TWO_WAY)
            begin
                lru_reg[row] <= !way_now;
            end
            if (hit_now)
            begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            acc_cnt_reg <= acc_cnt_reg + 1'b1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_out_reg <= hit_now;
            way_out_reg <= way_now;
        end
    end

    assign hit          = hit_out_reg;
    assign way_used     = way_out_reg;
    assign hit_total    = hit_cnt_reg;
    assign access_total = acc_cnt_reg;

    // Every commit counts one access
    a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (acc_cnt_reg == $past(acc_cnt_reg) + 1'b1))
        else $error("access counter did not advance");

    // Counters only move on commit
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> ($stable(acc_cnt_reg) && $stable(hit_cnt_reg)))
        else $error("counter moved without commit");

    // At most one tag way written per commit
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(we0 && we1))
        else $error("both tag ways written");

endmodule
